@@ hw/rtl/nnsi_pkg.sv @@
// ----------------------------------------------------------------------------
// nnsi_pkg
// Shared constants and types for the nearest-neighbor source index block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package nnsi_pkg;

  // Default parameter values for the top level.
  localparam int DEF_COORD_BITS = 12;
  localparam int DEF_FRAC_BITS  = 16;

  // Fixed register and field widths.
  localparam int SIZE_BITS      = 13;
  localparam int RATIO_BITS     = 24;
  localparam int OFFSET_BITS    = 24;
  localparam int CFG_DATA_BITS  = 24;
  localparam int CFG_INDEX_BITS = 3;

  // Unity scale in Q8.16.
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 24'd65536;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SOURCE_ROWS       = 3'd0,
    REG_SOURCE_COLS       = 3'd1,
    REG_ROW_RATIO         = 3'd2,
    REG_COL_RATIO         = 3'd3,
    REG_CORNER_ALIGN_MODE = 3'd4,
    REG_HALF_PIXEL_MODE   = 3'd5
  } cfg_reg_t;

  // Mapping mode bits.
  typedef struct packed {
    logic corner_align;
    logic half_pixel;
  } mode_t;

  // Load enables of the four pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

@@ hw/rtl/nnsi_cfg.sv @@
// ----------------------------------------------------------------------------
// nnsi_cfg
// Configuration registers; sizes are kept as clamp limits ready for use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnsi_cfg #(
  parameter int COORD_BITS = nnsi_pkg::DEF_COORD_BITS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [nnsi_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [nnsi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic      [COORD_BITS-1:0]                row_lim,
  output logic      [COORD_BITS-1:0]                col_lim,
  output logic      [COORD_BITS:0]                  col_size,
  output logic      [nnsi_pkg::RATIO_BITS-1:0]      row_ratio,
  output logic      [nnsi_pkg::RATIO_BITS-1:0]      col_ratio,
  output nnsi_pkg::mode_t                           mode
);

  localparam int CMP_BITS = (nnsi_pkg::SIZE_BITS > COORD_BITS + 1) ?
                            nnsi_pkg::SIZE_BITS : COORD_BITS + 1;

  logic [CMP_BITS-1:0]   size_ext;
  logic [CMP_BITS-1:0]   size_cap;
  logic [COORD_BITS-1:0] wr_lim;

  // A size of zero acts as one; a size above the coordinate range is capped.
  always_comb begin
    size_ext = CMP_BITS'(cfg_data[nnsi_pkg::SIZE_BITS-1:0]);
    size_cap = CMP_BITS'(1) << COORD_BITS;
    if (size_ext == '0) begin
      wr_lim = '0;
    end else if (size_ext > size_cap) begin
      wr_lim = COORD_BITS'(size_cap - CMP_BITS'(1));
    end else begin
      wr_lim = COORD_BITS'(size_ext - CMP_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_lim   <= '0;
      col_lim   <= '0;
      col_size  <= (COORD_BITS+1)'(1);
      row_ratio <= nnsi_pkg::RATIO_RESET;
      col_ratio <= nnsi_pkg::RATIO_RESET;
      mode      <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        nnsi_pkg::REG_SOURCE_ROWS: begin
          row_lim <= wr_lim;
        end
        nnsi_pkg::REG_SOURCE_COLS: begin
          col_lim  <= wr_lim;
          col_size <= (COORD_BITS+1)'(wr_lim) + (COORD_BITS+1)'(1);
        end
        nnsi_pkg::REG_ROW_RATIO: begin
          row_ratio <= cfg_data[nnsi_pkg::RATIO_BITS-1:0];
        end
        nnsi_pkg::REG_COL_RATIO: begin
          col_ratio <= cfg_data[nnsi_pkg::RATIO_BITS-1:0];
        end
        nnsi_pkg::REG_CORNER_ALIGN_MODE: begin
          mode.corner_align <= cfg_data[0];
        end
        nnsi_pkg::REG_HALF_PIXEL_MODE: begin
          mode.half_pixel <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nnsi_axis.sv @@
// ----------------------------------------------------------------------------
// nnsi_axis
// One axis: scale the coordinate, then round or floor and clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnsi_axis #(
  parameter int COORD_BITS = nnsi_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = nnsi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                            clk,
  input  wire nnsi_pkg::stage_en_t             en,
  input  wire nnsi_pkg::mode_t                 mode,
  input  wire logic [COORD_BITS-1:0]           coord,
  input  wire logic [nnsi_pkg::RATIO_BITS-1:0] ratio,
  input  wire logic [COORD_BITS-1:0]           lim,
  output logic      [COORD_BITS-1:0]           pick
);

  localparam int PROD_BITS = COORD_BITS + 1 + nnsi_pkg::RATIO_BITS;
  localparam int VAL_BITS  = PROD_BITS + 1;
  localparam int IDX_BITS  = VAL_BITS - FRAC_BITS - 1;

  logic [PROD_BITS-1:0] prod;
  logic [VAL_BITS-1:0]  val;
  logic [IDX_BITS-1:0]  idx;

  // Stage 1: (2c + h) * ratio, a value with FRAC_BITS+1 fraction bits.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod <= PROD_BITS'({coord, mode.half_pixel}) * PROD_BITS'(ratio);
    end
  end

  // Stage 2: add one half when rounding, drop the fraction, clamp.
  always_comb begin
    val = VAL_BITS'(prod);
    if (mode.corner_align) begin
      val = val + (VAL_BITS'(1) << FRAC_BITS);
    end
    idx = val[VAL_BITS-1:FRAC_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pick <= (idx > IDX_BITS'(lim)) ? lim : idx[COORD_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nnsi_offset.sv @@
// ----------------------------------------------------------------------------
// nnsi_offset
// Row-major offset of the picked pixel, with the picks carried alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nnsi_offset #(
  parameter int COORD_BITS = nnsi_pkg::DEF_COORD_BITS
) (
  input  wire logic                             clk,
  input  wire nnsi_pkg::stage_en_t              en,
  input  wire logic [COORD_BITS-1:0]            row_in,
  input  wire logic [COORD_BITS-1:0]            col_in,
  input  wire logic [COORD_BITS:0]              col_size,
  output logic      [COORD_BITS-1:0]            pick_row,
  output logic      [COORD_BITS-1:0]            pick_col,
  output logic      [nnsi_pkg::OFFSET_BITS-1:0] pick_offset
);

  localparam int PROD_BITS = 2 * COORD_BITS + 1;
  localparam int SUM_BITS  = (PROD_BITS >= nnsi_pkg::OFFSET_BITS) ?
                             PROD_BITS + 1 : nnsi_pkg::OFFSET_BITS + 1;

  logic [PROD_BITS-1:0]  prod;
  logic [COORD_BITS-1:0] row_q;
  logic [COORD_BITS-1:0] col_q;
  logic [SUM_BITS-1:0]   sum;

  // Stage 3: row times effective width.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      prod  <= PROD_BITS'(row_in) * PROD_BITS'(col_size);
      row_q <= row_in;
      col_q <= col_in;
    end
  end

  assign sum = SUM_BITS'(prod) + SUM_BITS'(col_q);

  // Stage 4: add the column; the offset wraps at its field width.
  always_ff @(posedge clk) begin
    if (en.s4) begin
      pick_offset <= sum[nnsi_pkg::OFFSET_BITS-1:0];
      pick_row    <= row_q;
      pick_col    <= col_q;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/nearest_neighbor_source_index.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_source_index
// Source pixel picker for nearest-neighbor image resizing.
// ----------------------------------------------------------------------------
// Each word on the input channel is one output pixel coordinate; each word on
// the output channel is the source pixel to copy from, as a row, a column and
// a row-major offset. The block takes one word per clock unless in_stall is
// raised. Each word moves through the four register stages in turn and is
// presented on the output channel from the last stage register. The four
// register stages are the scale multiply, the round and clamp, the offset
// multiply and the offset add. Stages that hold no word are filled even
// while the output is stalled, so up to four words can be held in flight.
// Per axis the coordinate c maps to
// floor((2c + h) * ratio / 2^(FRAC_BITS+1)), with h set in half-pixel mode;
// corner-align mode adds one half before the floor. The pick is clamped to
// size-1, where a size of zero acts as one. Configuration writes take effect
// on the next clock and must only be made while no word is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module nearest_neighbor_source_index #(
  parameter int COORD_BITS = nnsi_pkg::DEF_COORD_BITS,
  parameter int FRAC_BITS  = nnsi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Configuration write port.
  input  wire logic                                cfg_write,
  input  wire logic [nnsi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [nnsi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  // Input channel.
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [COORD_BITS-1:0]               dest_row,
  input  wire logic [COORD_BITS-1:0]               dest_col,
  // Output channel.
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic      [COORD_BITS-1:0]               pick_row,
  output logic      [COORD_BITS-1:0]               pick_col,
  output logic      [nnsi_pkg::OFFSET_BITS-1:0]    pick_offset
);

  logic [COORD_BITS-1:0]           row_lim;
  logic [COORD_BITS-1:0]           col_lim;
  logic [COORD_BITS:0]             col_size;
  logic [nnsi_pkg::RATIO_BITS-1:0] row_ratio;
  logic [nnsi_pkg::RATIO_BITS-1:0] col_ratio;
  nnsi_pkg::mode_t                 mode;

  // Valid bit of each stage; a stage may load when it is empty or when the
  // stage after it is loading.
  logic                  v1, v2, v3, v4;
  logic                  rdy1, rdy2, rdy3, rdy4;
  nnsi_pkg::stage_en_t   en;
  logic [COORD_BITS-1:0] row_s2;
  logic [COORD_BITS-1:0] col_s2;

  assign rdy4 = !v4 || !out_stall;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;
  assign en.s4 = rdy4;

  assign in_stall  = !rdy1;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy4) begin
        v4 <= v3;
      end
    end
  end

  nnsi_cfg #(
    .COORD_BITS (COORD_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .row_lim   (row_lim),
    .col_lim   (col_lim),
    .col_size  (col_size),
    .row_ratio (row_ratio),
    .col_ratio (col_ratio),
    .mode      (mode)
  );

  nnsi_axis #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_row_axis (
    .clk   (clk),
    .en    (en),
    .mode  (mode),
    .coord (dest_row),
    .ratio (row_ratio),
    .lim   (row_lim),
    .pick  (row_s2)
  );

  nnsi_axis #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_col_axis (
    .clk   (clk),
    .en    (en),
    .mode  (mode),
    .coord (dest_col),
    .ratio (col_ratio),
    .lim   (col_lim),
    .pick  (col_s2)
  );

  nnsi_offset #(
    .COORD_BITS (COORD_BITS)
  ) u_offset (
    .clk         (clk),
    .en          (en),
    .row_in      (row_s2),
    .col_in      (col_s2),
    .col_size    (col_size),
    .pick_row    (pick_row),
    .pick_col    (pick_col),
    .pick_offset (pick_offset)
  );

  // With the output never stalled, the pipeline must never push back.
  a_no_stall_when_drained: assert property (
    @(posedge clk) disable iff (rst) !out_stall |-> !in_stall
  ) else $error("input stalled while the output is free");

  // A taken word must occupy the first stage on the next clock.
  a_word_enters: assert property (
    @(posedge clk) disable iff (rst) (in_valid && !in_stall) |=> v1
  ) else $error("accepted word lost at the first stage");

  // Reset empties the pipeline.
  a_reset_empty: assert property (
    @(posedge clk) rst |=> !out_valid
  ) else $error("result shown right after reset");

endmodule

`default_nettype wire
